// ===== design/hmbd_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and address decode for the memory bus decoder
// no dependencies; used by every module in this folder
package hmbd_pkg;

    localparam int STORE_AW    = 15;
    localparam int STORE_DEPTH = 2 * 8192 + 512;

    localparam logic [15:0] ADDR_JOYP = 16'hFF00;
    localparam logic [15:0] ADDR_SC   = 16'hFF02;
    localparam logic [15:0] ADDR_DIV  = 16'hFF04;
    localparam logic [15:0] ADDR_TAC  = 16'hFF07;
    localparam logic [15:0] ADDR_IF   = 16'hFF0F;
    localparam logic [15:0] ADDR_NR14 = 16'hFF14;
    localparam logic [15:0] ADDR_NR24 = 16'hFF19;
    localparam logic [15:0] ADDR_NR34 = 16'hFF1E;
    localparam logic [15:0] ADDR_NR44 = 16'hFF23;
    localparam logic [15:0] ADDR_LCDC = 16'hFF40;
    localparam logic [15:0] ADDR_DMA  = 16'hFF46;
    localparam logic [15:0] ADDR_BOOT = 16'hFF50;
    localparam logic [15:0] ADDR_IE   = 16'hFFFF;

    localparam logic [2:0] CART_NONE      = 3'd0;
    localparam logic [2:0] CART_ROM_READ  = 3'd1;
    localparam logic [2:0] CART_ROM_WRITE = 3'd2;
    localparam logic [2:0] CART_RAM_READ  = 3'd3;
    localparam logic [2:0] CART_RAM_WRITE = 3'd4;

    localparam logic [2:0] SND_NONE = 3'd0;
    localparam logic [2:0] SND_CH1  = 3'd1;
    localparam logic [2:0] SND_CH2  = 3'd2;
    localparam logic [2:0] SND_CH3  = 3'd3;
    localparam logic [2:0] SND_CH4  = 3'd4;

    typedef enum logic [2:0] {
        RG_ROM,
        RG_VRAM,
        RG_XRAM,
        RG_WRAM,
        RG_ECHO,
        RG_OAM,
        RG_HIGH
    } region_t;

    typedef struct packed {
        logic        func;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  cart_read_data;
        logic        vram_busy;
        logic        oam_busy;
        logic [3:0]  pad_directions;
        logic [3:0]  pad_actions;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] cart_target;
        logic       divider_reset;
        logic [2:0] sound_channel;
        logic       sound_trigger;
        logic       sound_length_on;
        logic       lcd_off_reset;
        logic       dma_start;
        logic [7:0] dma_page;
    } result_t;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] index;
        logic [7:0]          data;
    } wb_t;

    function automatic region_t region_of(input logic [15:0] a);
        region_t r;
        r = RG_ROM;
        if (a[15])
        begin
            case (a[14:13])
                2'b00: r = RG_VRAM;
                2'b01: r = RG_XRAM;
                2'b10: r = RG_WRAM;
                default:
                begin
                    if (a[12:9] != 4'hF)
                        r = RG_ECHO;
                    else if (a[8])
                        r = RG_HIGH;
                    else
                        r = RG_OAM;
                end
            endcase
        end
        return r;
    endfunction

    // compacted store index: video ram, work ram (echo folds onto it), then fe00..ffff
    function automatic logic [STORE_AW-1:0] store_index(input logic [15:0] a);
        logic [STORE_AW-1:0] idx;
        case (region_of(a))
            RG_VRAM:         idx = {2'b00, a[12:0]};
            RG_WRAM, RG_ECHO: idx = {2'b01, a[12:0]};
            RG_OAM, RG_HIGH:  idx = {2'b10, 4'b0000, a[8:0]};
            default:         idx = '0;
        endcase
        return idx;
    endfunction

endpackage

// ===== design/hmbd_store.sv =====
`timescale 1ns / 1ps
// byte store with registered read and a clearing sweep after reset
// depends on hmbd_pkg
module hmbd_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [hmbd_pkg::STORE_AW-1:0] rd_index,
    output logic [7:0]                    rd_data,
    input  hmbd_pkg::wb_t                 wb,
    output logic                          clearing
);

    localparam logic [hmbd_pkg::STORE_AW-1:0] CLEAR_LAST =
        hmbd_pkg::STORE_AW'(hmbd_pkg::STORE_DEPTH - 1);

    logic [7:0]                    mem [hmbd_pkg::STORE_DEPTH];
    logic [7:0]                    rd_data_reg;
    logic                          clearing_reg;
    logic [hmbd_pkg::STORE_AW-1:0] clr_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == CLEAR_LAST)
                clearing_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clr_idx_reg] <= 8'h00;
        else if (wb.we)
            mem[wb.index] <= wb.data;
        if (rd_en)
            rd_data_reg <= mem[rd_index];
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

// ===== design/hmbd_update.sv =====
`timescale 1ns / 1ps
// memory map decode: result of one access and the store write-back
// depends on hmbd_pkg
module hmbd_update (
    input  hmbd_pkg::req_t    req,
    input  logic [7:0]        rd_data,
    input  logic              boot_done,
    output hmbd_pkg::result_t res,
    output hmbd_pkg::wb_t     wb
);

    hmbd_pkg::region_t region;
    logic [7:0]        v;
    logic [3:0]        nib;

    always_comb
    begin
        region   = hmbd_pkg::region_of(req.address);
        v        = req.write_data;
        nib      = 4'hF;
        res      = '0;
        wb.we    = 1'b0;
        wb.index = hmbd_pkg::store_index(req.address);
        wb.data  = v;
        if (!req.func)
        begin
            case (region)
                hmbd_pkg::RG_ROM:
                begin
                    // boot overlay area is never written, so it reads as zero
                    if (!(boot_done == 1'b0 && req.address[15:8] == 8'h00))
                    begin
                        res.read_data   = req.cart_read_data;
                        res.cart_target = hmbd_pkg::CART_ROM_READ;
                    end
                end
                hmbd_pkg::RG_VRAM:
                    res.read_data = req.vram_busy ? 8'hFF : rd_data;
                hmbd_pkg::RG_XRAM:
                begin
                    res.read_data   = req.cart_read_data;
                    res.cart_target = hmbd_pkg::CART_RAM_READ;
                end
                hmbd_pkg::RG_OAM:
                    res.read_data = req.oam_busy ? 8'hFF : rd_data;
                hmbd_pkg::RG_HIGH:
                begin
                    if (req.address == hmbd_pkg::ADDR_JOYP && rd_data[5:4] == 2'b11)
                        res.read_data = rd_data | 8'h0F;
                    else
                        res.read_data = rd_data;
                end
                default:
                    res.read_data = rd_data;
            endcase
        end
        else
        begin
            case (region)
                hmbd_pkg::RG_ROM:
                    res.cart_target = hmbd_pkg::CART_ROM_WRITE;
                hmbd_pkg::RG_VRAM:
                    wb.we = !req.vram_busy;
                hmbd_pkg::RG_XRAM:
                    res.cart_target = hmbd_pkg::CART_RAM_WRITE;
                hmbd_pkg::RG_OAM:
                    wb.we = !req.oam_busy;
                hmbd_pkg::RG_HIGH:
                begin
                    wb.we = 1'b1;
                    case (req.address)
                        hmbd_pkg::ADDR_JOYP:
                        begin
                            if (!v[4])
                                nib = req.pad_directions;
                            else if (!v[5])
                                nib = req.pad_actions;
                            wb.data = {rd_data[7:6], v[5:4], nib};
                        end
                        hmbd_pkg::ADDR_SC:
                            wb.data = 8'h7C | (v & 8'h81);
                        hmbd_pkg::ADDR_DIV:
                        begin
                            wb.data           = 8'h00;
                            res.divider_reset = 1'b1;
                        end
                        hmbd_pkg::ADDR_TAC:
                            wb.data = 8'hF8 | (v & 8'h07);
                        hmbd_pkg::ADDR_IF, hmbd_pkg::ADDR_IE:
                            wb.data = {rd_data[7:5], v[4:0]};
                        hmbd_pkg::ADDR_NR14, hmbd_pkg::ADDR_NR24,
                        hmbd_pkg::ADDR_NR34, hmbd_pkg::ADDR_NR44:
                        begin
                            wb.data             = v & 8'hC7;
                            res.sound_trigger   = v[7];
                            res.sound_length_on = v[6];
                            case (req.address)
                                hmbd_pkg::ADDR_NR14: res.sound_channel = hmbd_pkg::SND_CH1;
                                hmbd_pkg::ADDR_NR24: res.sound_channel = hmbd_pkg::SND_CH2;
                                hmbd_pkg::ADDR_NR34: res.sound_channel = hmbd_pkg::SND_CH3;
                                default:             res.sound_channel = hmbd_pkg::SND_CH4;
                            endcase
                        end
                        hmbd_pkg::ADDR_LCDC:
                            res.lcd_off_reset = !v[7];
                        hmbd_pkg::ADDR_DMA:
                        begin
                            wb.we         = 1'b0;
                            res.dma_start = 1'b1;
                            res.dma_page  = v;
                        end
                        hmbd_pkg::ADDR_BOOT:
                            wb.we = !rd_data[0];
                        default:
                            wb.data = v;
                    endcase
                end
                default:
                    wb.we = 1'b1;
            endcase
        end
    end

endmodule

// ===== design/handheld_memory_bus_decoder.sv =====
`timescale 1ns / 1ps
// order: accept with the store read registered, then a write-back cycle on the same entry
// in which the result is registered; input is not ready during write-back or while a
// result waits for m_tready, so a new access is taken only once the last is written back
// reset: input not ready while the store is swept to zero
// depends on hmbd_pkg, hmbd_store, hmbd_update
module handheld_memory_bus_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // address, write_data, cart_read_data, vram_busy,
                                  // oam_busy, pad_directions, pad_actions, zero fill
    input  logic [0:0]  s_tuser,  // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // read_data, cart_target, divider_reset, sound_channel,
                                  // sound_trigger, sound_length_on, lcd_off_reset,
                                  // dma_start, dma_page, zero fill
);

    hmbd_pkg::req_t    req_in;
    hmbd_pkg::req_t    req_reg;
    hmbd_pkg::result_t res;
    hmbd_pkg::wb_t     wb;
    hmbd_pkg::wb_t     wb_store;
    logic [7:0]        rd_data;
    logic              clearing;
    logic              accept;
    logic              busy_reg;
    logic              boot_done_reg;
    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;

    always_comb
    begin
        req_in.func           = s_tuser[0];
        req_in.address        = s_tdata[15:0];
        req_in.write_data     = s_tdata[23:16];
        req_in.cart_read_data = s_tdata[31:24];
        req_in.vram_busy      = s_tdata[32];
        req_in.oam_busy       = s_tdata[33];
        req_in.pad_directions = s_tdata[37:34];
        req_in.pad_actions    = s_tdata[41:38];
    end

    assign s_tready = !clearing && !busy_reg && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // write back only in the cycle after the read
    always_comb
    begin
        wb_store    = wb;
        wb_store.we = wb.we && busy_reg;
    end

    hmbd_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_index (hmbd_pkg::store_index(req_in.address)),
        .rd_data  (rd_data),
        .wb       (wb_store),
        .clearing (clearing)
    );

    hmbd_update u_update (
        .req       (req_reg),
        .rd_data   (rd_data),
        .boot_done (boot_done_reg),
        .res       (res),
        .wb        (wb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            boot_done_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= accept;
            if (busy_reg)
            begin
                m_tvalid_reg <= 1'b1;
                if (wb.we && req_reg.address == hmbd_pkg::ADDR_BOOT)
                    boot_done_reg <= wb.data[0];
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req_in;
        if (busy_reg)
            m_tdata_reg <= {5'b00000, res.dma_page, res.dma_start, res.lcd_off_reset,
                            res.sound_length_on, res.sound_trigger, res.sound_channel,
                            res.divider_reset, res.cart_target, res.read_data};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> m_tvalid && !busy_reg)
        else $error("result not presented after write-back cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted transfer did not enter write-back");

    a_wb_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wb_store.we |-> busy_reg && !accept)
        else $error("read issued beside a stray store write");

    a_boot_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        boot_done_reg |=> boot_done_reg)
        else $error("boot latch cleared after being set");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !busy_reg && !m_tvalid)
        else $error("access in flight during store sweep");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for handheld_memory_bus_decoder: directed and random bus accesses,
// each result checked against a byte-level model of the memory map held in the bench
// depends on hmbd_pkg and the decoder rtl
module tb_top;

    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    localparam logic [15:0] ROM_END     = 16'h7FFF;
    localparam logic [15:0] BOOT_END    = 16'h00FF;
    localparam logic [15:0] VRAM_END    = 16'h9FFF;
    localparam logic [15:0] XRAM_END    = 16'hBFFF;
    localparam logic [15:0] WRAM_END    = 16'hDFFF;
    localparam logic [15:0] ECHO_END    = 16'hFDFF;
    localparam logic [15:0] OAM_END     = 16'hFEFF;
    localparam logic [15:0] ECHO_OFFSET = 16'h2000;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_PHASE   = 225;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;  // address, write_data, cart_read_data, vram_busy,
                                // oam_busy, pad_directions, pad_actions, zero fill
    logic [0:0]  s_tuser = '0;  // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;       // read_data, cart_target, divider_reset, sound_channel,
                                // sound_trigger, sound_length_on, lcd_off_reset,
                                // dma_start, dma_page, zero fill

    logic [7:0]        bus_image [0:65535];
    hmbd_pkg::result_t expected_results [$];
    int                errors = 0;
    int                quiet_cycles = 0;
    int                idle_pct = 0;
    int                stall_pct = 0;

    handheld_memory_bus_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // applies one access to the bus image and returns the result it should give
    function automatic hmbd_pkg::result_t decode_access(input hmbd_pkg::req_t r);
        hmbd_pkg::result_t res;
        logic [15:0]       a;
        logic [7:0]        v;
        logic [3:0]        nib;
        res = '0;
        a = r.address;
        v = r.write_data;
        if (r.func == ACC_READ)
        begin
            if (a <= ROM_END)
            begin
                if (!bus_image[hmbd_pkg::ADDR_BOOT][0] && a <= BOOT_END)
                    res.read_data = bus_image[a];
                else
                begin
                    res.read_data = r.cart_read_data;
                    res.cart_target = hmbd_pkg::CART_ROM_READ;
                end
            end
            else if (a <= VRAM_END)
                res.read_data = r.vram_busy ? 8'hFF : bus_image[a];
            else if (a <= XRAM_END)
            begin
                res.read_data = r.cart_read_data;
                res.cart_target = hmbd_pkg::CART_RAM_READ;
            end
            else if (a <= WRAM_END)
                res.read_data = bus_image[a];
            else if (a <= ECHO_END)
                res.read_data = bus_image[a - ECHO_OFFSET];
            else if (a <= OAM_END)
                res.read_data = r.oam_busy ? 8'hFF : bus_image[a];
            else if (a == hmbd_pkg::ADDR_JOYP && bus_image[a][5:4] == 2'b11)
                res.read_data = bus_image[a] | 8'h0F;
            else
                res.read_data = bus_image[a];
        end
        else if (a <= ROM_END)
            res.cart_target = hmbd_pkg::CART_ROM_WRITE;
        else if (a <= VRAM_END)
        begin
            if (!r.vram_busy)
                bus_image[a] = v;
        end
        else if (a <= XRAM_END)
            res.cart_target = hmbd_pkg::CART_RAM_WRITE;
        else if (a <= WRAM_END)
            bus_image[a] = v;
        else if (a <= ECHO_END)
            bus_image[a - ECHO_OFFSET] = v;
        else if (a <= OAM_END)
        begin
            if (!r.oam_busy)
                bus_image[a] = v;
        end
        else
        begin
            case (a)
                hmbd_pkg::ADDR_JOYP:
                begin
                    if (!v[4])
                        nib = r.pad_directions;
                    else if (!v[5])
                        nib = r.pad_actions;
                    else
                        nib = 4'hF;
                    bus_image[a] = {bus_image[a][7:6], v[5:4], nib};
                end
                hmbd_pkg::ADDR_SC:
                    bus_image[a] = 8'h7C | (v & 8'h81);
                hmbd_pkg::ADDR_DIV:
                begin
                    bus_image[a] = 8'h00;
                    res.divider_reset = 1'b1;
                end
                hmbd_pkg::ADDR_TAC:
                    bus_image[a] = 8'hF8 | (v & 8'h07);
                hmbd_pkg::ADDR_IF, hmbd_pkg::ADDR_IE:
                    bus_image[a] = (bus_image[a] & 8'hE0) | (v & 8'h1F);
                hmbd_pkg::ADDR_NR14, hmbd_pkg::ADDR_NR24,
                hmbd_pkg::ADDR_NR34, hmbd_pkg::ADDR_NR44:
                begin
                    bus_image[a] = v & 8'hC7;
                    case (a)
                        hmbd_pkg::ADDR_NR14: res.sound_channel = hmbd_pkg::SND_CH1;
                        hmbd_pkg::ADDR_NR24: res.sound_channel = hmbd_pkg::SND_CH2;
                        hmbd_pkg::ADDR_NR34: res.sound_channel = hmbd_pkg::SND_CH3;
                        default:             res.sound_channel = hmbd_pkg::SND_CH4;
                    endcase
                    res.sound_trigger = v[7];
                    res.sound_length_on = v[6];
                end
                hmbd_pkg::ADDR_LCDC:
                begin
                    bus_image[a] = v;
                    res.lcd_off_reset = !v[7];
                end
                hmbd_pkg::ADDR_DMA:
                begin
                    res.dma_start = 1'b1;
                    res.dma_page = v;
                end
                hmbd_pkg::ADDR_BOOT:
                begin
                    if (!bus_image[a][0])
                        bus_image[a] = v;
                end
                default:
                    bus_image[a] = v;
            endcase
        end
        return res;
    endfunction

    task automatic send_access(input hmbd_pkg::req_t r);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        s_tdata <= {6'b0, r.pad_actions, r.pad_directions, r.oam_busy, r.vram_busy,
                    r.cart_read_data, r.write_data, r.address};
        s_tuser <= r.func;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(decode_access(r));
    endtask

    task automatic bus_op(input logic func, input logic [15:0] a, input logic [7:0] data,
                          input logic [7:0] cart, input logic vlock, input logic olock,
                          input logic [3:0] dirs, input logic [3:0] acts);
        hmbd_pkg::req_t r;
        r.func = func;
        r.address = a;
        r.write_data = data;
        r.cart_read_data = cart;
        r.vram_busy = vlock;
        r.oam_busy = olock;
        r.pad_directions = dirs;
        r.pad_actions = acts;
        send_access(r);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // result check and watchdog
    always @(posedge clk)
    begin
        hmbd_pkg::result_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("read_data", int'(want.read_data), int'(m_tdata[7:0]));
                    compare_field("cart_target", int'(want.cart_target),
                                  int'(m_tdata[10:8]));
                    compare_field("divider_reset", int'(want.divider_reset),
                                  int'(m_tdata[11]));
                    compare_field("sound_channel", int'(want.sound_channel),
                                  int'(m_tdata[14:12]));
                    compare_field("sound_trigger", int'(want.sound_trigger),
                                  int'(m_tdata[15]));
                    compare_field("sound_length_on", int'(want.sound_length_on),
                                  int'(m_tdata[16]));
                    compare_field("lcd_off_reset", int'(want.lcd_off_reset),
                                  int'(m_tdata[17]));
                    compare_field("dma_start", int'(want.dma_start), int'(m_tdata[18]));
                    compare_field("dma_page", int'(want.dma_page), int'(m_tdata[26:19]));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [15:0] pick_address();
        logic [15:0] a;
        logic [15:0] k;
        logic        hi;
        k = 16'($urandom_range(15));
        hi = 1'($urandom_range(1));
        case ($urandom_range(8))
            0: a = 16'($urandom_range(16'hFFFF));
            1: a = hi ? 16'($urandom_range(ROM_END)) : 16'($urandom_range(BOOT_END));
            2: a = hi ? 16'h9FF0 + k : 16'h8000 + k;
            3: a = hi ? 16'hDDF0 + k : 16'hC000 + k;
            4: a = hi ? 16'hFDF0 + k : 16'hE000 + k;
            5: a = hi ? 16'hFEF0 + k : 16'hFE00 + k;
            6: a = hi ? 16'hFF80 + k : 16'hA000 + 16'($urandom_range(16'h1FFF));
            default:
            begin
                case ($urandom_range(12))
                    0:  a = hmbd_pkg::ADDR_JOYP;
                    1:  a = hmbd_pkg::ADDR_SC;
                    2:  a = hmbd_pkg::ADDR_DIV;
                    3:  a = hmbd_pkg::ADDR_TAC;
                    4:  a = hmbd_pkg::ADDR_IF;
                    5:  a = hmbd_pkg::ADDR_NR14;
                    6:  a = hmbd_pkg::ADDR_NR24;
                    7:  a = hmbd_pkg::ADDR_NR34;
                    8:  a = hmbd_pkg::ADDR_NR44;
                    9:  a = hmbd_pkg::ADDR_LCDC;
                    10: a = hmbd_pkg::ADDR_DMA;
                    11: a = hmbd_pkg::ADDR_BOOT;
                    default: a = hmbd_pkg::ADDR_IE;
                endcase
            end
        endcase
        return a;
    endfunction

    task automatic test_memory_map();
        bus_op(ACC_READ, 16'h0000, 8'h00, 8'hA5, 1'b0, 1'b0, 4'h0, 4'hF);
        bus_op(ACC_READ, 16'h00FF, 8'hFF, 8'hFF, 1'b1, 1'b1, 4'hF, 4'h0);
        bus_op(ACC_READ, 16'h0100, 8'h00, 8'h5A, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, 16'h0000, 8'hFF, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, 16'h7FFF, 8'h3C, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, 16'hA000, 8'h12, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_READ, 16'hBFFF, 8'h00, 8'hC3, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, 16'h8000, 8'hFF, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_READ, 16'h8000, 8'h00, 8'h00, 1'b1, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, 16'h9FFF, 8'h3C, 8'h00, 1'b1, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_READ, 16'h9FFF, 8'h00, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, 16'hFDFF, 8'h81, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_READ, 16'hDDFF, 8'h00, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, 16'hFEFF, 8'hAA, 8'h00, 1'b0, 1'b1, 4'h0, 4'h0);
        bus_op(ACC_READ, 16'hFEFF, 8'h00, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    endtask

    task automatic test_io_registers();
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_JOYP, 8'h20, 8'h00, 1'b0, 1'b0, 4'h5, 4'hA);
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_JOYP, 8'h10, 8'h00, 1'b0, 1'b0, 4'h5, 4'hA);
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_JOYP, 8'hFF, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_READ, hmbd_pkg::ADDR_JOYP, 8'h00, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_SC, 8'hFF, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_DIV, 8'hFF, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_TAC, 8'h00, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_IF, 8'hFF, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_IE, 8'hE0, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_NR14, 8'hFF, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_NR44, 8'h40, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_LCDC, 8'h7F, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_LCDC, 8'h80, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_DMA, 8'hFF, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    endtask

    // latch is write-once: the second write must not reopen the overlay
    task automatic test_boot_latch();
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_BOOT, 8'h01, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_WRITE, hmbd_pkg::ADDR_BOOT, 8'h00, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_READ, 16'h0000, 8'h00, 8'h96, 1'b0, 1'b0, 4'h0, 4'h0);
        bus_op(ACC_READ, hmbd_pkg::ADDR_BOOT, 8'h00, 8'h00, 1'b0, 1'b0, 4'h0, 4'h0);
    endtask

    // while the overlay is still wanted, writes to the latch keep bit 0 clear
    task automatic test_random(input int count, input int idle, input int stall,
                               input bit latch_free);
        hmbd_pkg::req_t r;
        idle_pct = idle;
        stall_pct = stall;
        repeat (count)
        begin
            r.func = 1'($urandom_range(1));
            r.address = pick_address();
            r.write_data = 8'($urandom_range(255));
            r.cart_read_data = 8'($urandom_range(255));
            r.vram_busy = ($urandom_range(3) == 0);
            r.oam_busy = ($urandom_range(3) == 0);
            r.pad_directions = 4'($urandom_range(15));
            r.pad_actions = 4'($urandom_range(15));
            if (!latch_free && r.func == ACC_WRITE && r.address == hmbd_pkg::ADDR_BOOT)
                r.write_data[0] = 1'b0;
            send_access(r);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 65536; i++)
            bus_image[i] = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_memory_map();
        test_io_registers();
        test_random(RANDOM_PHASE, 0, 0, 1'b0);
        test_random(RANDOM_PHASE, 57, 0, 1'b0);
        test_boot_latch();
        test_random(RANDOM_PHASE, 0, 57, 1'b1);
        test_random(RANDOM_PHASE, 7, 7, 1'b1);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/hmbd_pkg.sv
design/hmbd_store.sv
design/hmbd_update.sv
design/handheld_memory_bus_decoder.sv
tb/sv/tb_top.sv
